[sv/tbp_pkg.sv]
`default_nettype none

package tbp_pkg;

    // Controller states: clearing pass after reset, waiting for a
    // transaction, and the read-modify-write step of an accepted one.
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } state_t;

    // One table entry as it sits in the memory.
    typedef struct packed {
        logic        valid;
        logic [31:0] tag;
        logic [31:0] target;
        logic [1:0]  ctr;
    } entry_t;

    localparam logic [1:0] CTR_SNT = 2'b00;
    localparam logic [1:0] CTR_WNT = 2'b01;
    localparam logic [1:0] CTR_WT  = 2'b10;
    localparam logic [1:0] CTR_ST  = 2'b11;

    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_RESOLVE = 1'b1;

    localparam logic [1:0] VERDICT_NONE = 2'd0;
    localparam logic [1:0] VERDICT_HIT  = 2'd1;
    localparam logic [1:0] VERDICT_MISS = 2'd2;

    localparam logic [31:0] INSN_BYTES = 32'd4;

    localparam entry_t RESET_ENTRY = '{
        valid:  1'b0,
        tag:    32'hFFFF_FFFF,
        target: 32'hFFFF_FFFF,
        ctr:    CTR_WNT
    };

endpackage

`default_nettype wire

[sv/tagged_two_bit_branch_predictor_top.sv]
`default_nettype none

// Channel   | Direction | Handshake          | Carries
// ----------+-----------+--------------------+-----------------------------------------
// s_        | in        | s_valid / s_ready  | predict lookup or resolved branch outcome
// m_        | out       | m_valid / m_ready  | prediction, redirect, verdict and tallies
//
// Every transaction reads its table entry from the synchronous memory in the
// accept cycle; in the write-back step the result is loaded into the output
// register, and a resolve that trains or allocates an entry writes it back.
// After reset a clearing pass writes every entry once, during which s_ready
// stays low.
// A result waiting in the output register does not block the next accept;
// only the write-back step holds while that register is still full.

module tagged_two_bit_branch_predictor_top #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_mode,
    input  wire logic [31:0]        s_fetch_pc,
    input  wire logic [5:0]         s_slot,
    input  wire logic               s_was_found,
    input  wire logic               s_was_predicted_taken,
    input  wire logic [31:0]        s_next_sequential,
    input  wire logic signed [15:0] s_offset,
    input  wire logic               s_actually_taken,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_hit_tag,
    output logic                    m_guess_taken,
    output logic [5:0]              m_table_slot,
    output logic [31:0]             m_fall_through,
    output logic [31:0]             m_next_fetch,
    output logic                    m_redirect,
    output logic [31:0]             m_redirect_pc,
    output logic [1:0]              m_verdict,
    output logic [31:0]             m_hits_so_far,
    output logic [31:0]             m_misses_so_far
);

    import tbp_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [31:0]      IDX_MASK = 32'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Control state.
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;
    logic             m_valid_reg;
    logic [31:0]      hit_tally_reg, miss_tally_reg;

    // Captured request of the transaction in flight.
    logic              req_mode_reg;
    logic [31:0]       req_pc_reg;
    logic [IDX_W-1:0]  req_idx_reg;
    logic              req_found_reg;
    logic              req_guessed_reg;
    logic [31:0]       req_nseq_reg;
    logic signed [15:0] req_off_reg;
    logic              req_taken_reg;

    // Table memory and its registered read port.
    entry_t           mem_array [TABLE_ENTRIES];
    entry_t           rd_entry_reg;
    logic [IDX_W-1:0] rd_idx;
    logic             in_accept;

    // Write port.
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    // Result of the write-back step.
    logic             out_load;
    logic             upd_we;
    entry_t           upd_entry;
    logic             res_hit_tag, res_guess, res_redirect;
    logic [5:0]       res_slot;
    logic [31:0]      res_fall_through, res_next_fetch, res_redirect_pc;
    logic [1:0]       res_verdict;
    logic [31:0]      hit_tally_next, miss_tally_next;

    // Output register.
    logic             m_hit_tag_reg, m_guess_taken_reg, m_redirect_reg;
    logic [5:0]       m_table_slot_reg;
    logic [31:0]      m_fall_through_reg, m_next_fetch_reg, m_redirect_pc_reg;
    logic [1:0]       m_verdict_reg;
    logic [31:0]      m_hits_reg, m_misses_reg;

    assign in_accept = s_valid && s_ready;

    // A predict looks up by the word address, a resolve by the returned slot.
    always_comb begin
        if (s_mode == MODE_PREDICT) begin
            rd_idx = IDX_W'((s_fetch_pc >> 2) & IDX_MASK);
        end else begin
            rd_idx = IDX_W'(32'(s_slot) & IDX_MASK);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rd_entry_reg <= mem_array[rd_idx];
        end
    end

    // Reads happen only in the idle state and writes only in the clear and
    // write-back states, so a read never overlaps a write to the same entry.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_array[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            req_mode_reg    <= s_mode;
            req_pc_reg      <= s_fetch_pc;
            req_idx_reg     <= rd_idx;
            req_found_reg   <= s_was_found;
            req_guessed_reg <= s_was_predicted_taken;
            req_nseq_reg    <= s_next_sequential;
            req_off_reg     <= s_offset;
            req_taken_reg   <= s_actually_taken;
        end
    end

    // Prediction and training logic, working on the entry just read.
    always_comb begin
        logic [31:0] idx_wide;
        logic [31:0] branch_tgt;
        logic [1:0]  c;

        idx_wide         = 32'(req_idx_reg);
        branch_tgt       = req_nseq_reg + {{14{req_off_reg[15]}}, req_off_reg, 2'b00};
        c                = rd_entry_reg.ctr;

        res_hit_tag      = 1'b0;
        res_guess        = 1'b0;
        res_slot         = 6'd0;
        res_fall_through = 32'd0;
        res_next_fetch   = 32'd0;
        res_redirect     = 1'b0;
        res_redirect_pc  = 32'd0;
        res_verdict      = VERDICT_NONE;
        hit_tally_next   = hit_tally_reg;
        miss_tally_next  = miss_tally_reg;
        upd_we           = 1'b0;
        upd_entry        = rd_entry_reg;

        if (req_mode_reg == MODE_PREDICT) begin
            res_hit_tag      = rd_entry_reg.valid && (rd_entry_reg.tag == req_pc_reg);
            res_guess        = res_hit_tag && rd_entry_reg.ctr[1];
            res_slot         = idx_wide[5:0];
            res_fall_through = req_pc_reg + INSN_BYTES;
            res_next_fetch   = res_guess ? rd_entry_reg.target : res_fall_through;
        end else if (req_found_reg) begin
            upd_we = 1'b1;
            if (req_guessed_reg == req_taken_reg) begin
                res_verdict    = VERDICT_HIT;
                hit_tally_next = hit_tally_reg + 32'd1;
                if (req_taken_reg && c == CTR_WT) begin
                    c = CTR_ST;
                end else if (!req_taken_reg && c == CTR_WNT) begin
                    c = CTR_SNT;
                end
            end else begin
                res_verdict     = VERDICT_MISS;
                miss_tally_next = miss_tally_reg + 32'd1;
                res_redirect    = 1'b1;
                if (req_guessed_reg) begin
                    if (c[1]) begin
                        c = c - 2'd1;
                    end
                    res_redirect_pc = req_nseq_reg;
                end else begin
                    if (!c[1]) begin
                        c = c + 2'd1;
                    end
                    res_redirect_pc = rd_entry_reg.target;
                end
            end
            upd_entry.ctr = c;
        end else if (req_taken_reg) begin
            // A taken branch that missed the table is allocated strongly taken.
            res_verdict      = VERDICT_MISS;
            miss_tally_next  = miss_tally_reg + 32'd1;
            res_redirect     = 1'b1;
            res_redirect_pc  = branch_tgt;
            upd_we           = 1'b1;
            upd_entry.valid  = 1'b1;
            upd_entry.tag    = req_nseq_reg - INSN_BYTES;
            upd_entry.target = branch_tgt;
            upd_entry.ctr    = CTR_ST;
        end
    end

    // Controller.
    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        s_ready      = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = clr_idx_reg;
        mem_wdata    = RESET_ENTRY;
        out_load     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    mem_we     = upd_we;
                    mem_waddr  = req_idx_reg;
                    mem_wdata  = upd_entry;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            m_valid_reg    <= 1'b0;
            hit_tally_reg  <= 32'd0;
            miss_tally_reg <= 32'd0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            if (out_load) begin
                m_valid_reg    <= 1'b1;
                hit_tally_reg  <= hit_tally_next;
                miss_tally_reg <= miss_tally_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_hit_tag_reg      <= res_hit_tag;
            m_guess_taken_reg  <= res_guess;
            m_table_slot_reg   <= res_slot;
            m_fall_through_reg <= res_fall_through;
            m_next_fetch_reg   <= res_next_fetch;
            m_redirect_reg     <= res_redirect;
            m_redirect_pc_reg  <= res_redirect_pc;
            m_verdict_reg      <= res_verdict;
            m_hits_reg         <= hit_tally_next;
            m_misses_reg       <= miss_tally_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit_tag       = m_hit_tag_reg;
    assign m_guess_taken   = m_guess_taken_reg;
    assign m_table_slot    = m_table_slot_reg;
    assign m_fall_through  = m_fall_through_reg;
    assign m_next_fetch    = m_next_fetch_reg;
    assign m_redirect      = m_redirect_reg;
    assign m_redirect_pc   = m_redirect_pc_reg;
    assign m_verdict       = m_verdict_reg;
    assign m_hits_so_far   = m_hits_reg;
    assign m_misses_so_far = m_misses_reg;

    // An accepted transaction always moves on to its write-back step.
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> state_reg == ST_EXEC)
        else $error("accepted transaction did not enter the write-back step");

    // The tallies move only when a result is loaded.
    a_tally_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_load |=> $stable(hit_tally_reg) && $stable(miss_tally_reg))
        else $error("tally changed without a result");

    // A redirect is only ever raised for a misprediction.
    a_redirect_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_redirect_reg |-> m_verdict_reg == VERDICT_MISS)
        else $error("redirect without a miss verdict");

    // The table is written only by the clearing pass or a resolve write-back.
    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> state_reg == ST_CLEAR || (out_load && req_mode_reg == MODE_RESOLVE))
        else $error("unexpected table write");

endmodule

`default_nettype wire
